FILE: hw/rtl/tdpt_pkg.sv
package tdpt_pkg;

	localparam int unsigned VALUE_WIDTH_DEF = 20;

	typedef struct packed {
		logic done;
		logic zero;
	} tdpt_mod_res_t;

endpackage

FILE: hw/rtl/tdpt_cand_if.sv
interface tdpt_cand_if #(
	parameter int unsigned WIDTH = tdpt_pkg::VALUE_WIDTH_DEF
);
	logic             valid;
	logic             ready;
	logic [WIDTH-1:0] candidate;
	logic             last_of_range;

	modport source (output valid, output candidate, output last_of_range, input ready);
	modport sink   (input valid, input candidate, input last_of_range, output ready);
endinterface

FILE: hw/rtl/tdpt_verdict_if.sv
interface tdpt_verdict_if #(
	parameter int unsigned WIDTH = tdpt_pkg::VALUE_WIDTH_DEF
);
	logic             valid;
	logic             ready;
	logic [WIDTH-1:0] number;
	logic             is_prime;
	logic             last_out;

	modport source (output valid, output number, output is_prime, output last_out, input ready);
	modport sink   (input valid, input number, input is_prime, input last_out, output ready);
endinterface

FILE: hw/rtl/tdpt_mod_unit.sv
module tdpt_mod_unit #(
	parameter int unsigned VALUE_WIDTH = tdpt_pkg::VALUE_WIDTH_DEF,
	parameter int unsigned DIV_WIDTH   = (tdpt_pkg::VALUE_WIDTH_DEF + 1) / 2 + 1
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic [VALUE_WIDTH-1:0]  dividend,
	input  logic [DIV_WIDTH-1:0]    divisor,
	output tdpt_pkg::tdpt_mod_res_t res
);
	import tdpt_pkg::*;

	localparam int unsigned CW = $clog2(VALUE_WIDTH + 1);

	logic                   busy_q;
	logic                   done_q;
	logic [CW-1:0]          cnt_q;
	logic [VALUE_WIDTH-1:0] dvd_q;
	logic [DIV_WIDTH-1:0]   rem_q;
	logic [DIV_WIDTH:0]     trial;
	logic [DIV_WIDTH-1:0]   rem_nxt;

	// one quotient bit per cycle, restoring
	always_comb begin
		trial = {rem_q, dvd_q[VALUE_WIDTH-1]};
		if (trial >= {1'b0, divisor}) begin
			rem_nxt = DIV_WIDTH'(trial - {1'b0, divisor});
		end else begin
			rem_nxt = trial[DIV_WIDTH-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(VALUE_WIDTH);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= dvd_q << 1;
			rem_q <= rem_nxt;
		end
	end

	assign res.done = done_q;
	assign res.zero = (rem_q == '0);

endmodule

FILE: hw/rtl/trial_division_prime_test.sv
// Trial-division primality test. Each candidate transfer is answered by exactly one
// verdict transfer carrying the candidate, a prime flag (0 and 1 count as not prime)
// and the interval-end flag. Divisors d = 2, 3, ... are tried while d*d <= candidate,
// stopping at the first that divides evenly; each trial runs through one shared
// bit-serial remainder unit. The candidate channel is not ready while an item is
// in work; a finished verdict waits in an output register while the next
// candidate is taken.
module trial_division_prime_test #(
	parameter int unsigned VALUE_WIDTH = tdpt_pkg::VALUE_WIDTH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	tdpt_cand_if.sink      candidates,
	tdpt_verdict_if.source verdicts
);
	import tdpt_pkg::*;

	localparam int unsigned DW = (VALUE_WIDTH + 1) / 2 + 1;
	localparam int unsigned SW = 2 * DW;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_CHECK = 4'b0010,
		ST_DIV   = 4'b0100,
		ST_DONE  = 4'b1000
	} state_t;

	state_t                 state_q;
	logic [VALUE_WIDTH-1:0] n_q;
	logic                   last_q;
	logic                   prime_q;
	logic [DW-1:0]          d_q;
	logic [SW-1:0]          sq_q;
	logic                   out_vld_q;
	logic [VALUE_WIDTH-1:0] out_num_q;
	logic                   out_prime_q;
	logic                   out_last_q;

	tdpt_mod_res_t mres;
	logic          in_xfer;
	logic          sq_gt;
	logic          mod_start;
	logic          out_free;
	logic          out_load;

	assign in_xfer   = candidates.valid && candidates.ready;
	assign sq_gt     = sq_q > SW'(n_q);
	assign mod_start = (state_q == ST_CHECK) && !sq_gt;
	assign out_free  = !out_vld_q || verdicts.ready;
	assign out_load  = (state_q == ST_DONE) && out_free;

	assign candidates.ready = (state_q == ST_IDLE);

	tdpt_mod_unit #(
		.VALUE_WIDTH(VALUE_WIDTH),
		.DIV_WIDTH  (DW)
	) u_mod (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mod_start),
		.dividend(n_q),
		.divisor (d_q),
		.res     (mres)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						if (candidates.candidate < VALUE_WIDTH'(2)) begin
							state_q <= ST_DONE;
						end else begin
							state_q <= ST_CHECK;
						end
					end
				end
				ST_CHECK: begin
					if (sq_gt) begin
						state_q <= ST_DONE;
					end else begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (mres.done) begin
						if (mres.zero) begin
							state_q <= ST_DONE;
						end else begin
							state_q <= ST_CHECK;
						end
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// working values, (d+1)^2 = d^2 + 2d + 1
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			n_q     <= candidates.candidate;
			last_q  <= candidates.last_of_range;
			d_q     <= DW'(2);
			sq_q    <= SW'(4);
			prime_q <= 1'b0;
		end else if (state_q == ST_CHECK && sq_gt) begin
			prime_q <= 1'b1;
		end else if (state_q == ST_DIV && mres.done && !mres.zero) begin
			d_q  <= d_q + DW'(1);
			sq_q <= sq_q + SW'({d_q, 1'b1});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (out_load) begin
			out_vld_q <= 1'b1;
		end else if (verdicts.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_num_q   <= n_q;
			out_prime_q <= prime_q;
			out_last_q  <= last_q;
		end
	end

	assign verdicts.valid    = out_vld_q;
	assign verdicts.number   = out_num_q;
	assign verdicts.is_prime = out_prime_q;
	assign verdicts.last_out = out_last_q;

endmodule

FILE: hw/rtl/tdpt_checker.sv
module tdpt_checker #(
	parameter int unsigned VALUE_WIDTH = tdpt_pkg::VALUE_WIDTH_DEF
) (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   in_valid,
	input logic                   in_ready,
	input logic                   out_valid,
	input logic                   out_ready,
	input logic [VALUE_WIDTH-1:0] out_number,
	input logic                   out_is_prime
);
	import tdpt_pkg::*;

	// verdict held until transferred
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_number) && $stable(out_is_prime))
		else $error("verdict dropped or changed while stalled");

	// one candidate at a time
	a_busy_after_xfer: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("candidate channel ready straight after a transfer");

	a_small_not_prime: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_is_prime |-> out_number >= VALUE_WIDTH'(2))
		else $error("zero or one reported as prime");

	a_two_prime: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_number == VALUE_WIDTH'(2) |-> out_is_prime)
		else $error("two reported as not prime");

endmodule

bind trial_division_prime_test tdpt_checker #(
	.VALUE_WIDTH(VALUE_WIDTH)
) u_tdpt_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (candidates.valid),
	.in_ready    (candidates.ready),
	.out_valid   (verdicts.valid),
	.out_ready   (verdicts.ready),
	.out_number  (verdicts.number),
	.out_is_prime(verdicts.is_prime)
);
